// ===== src/pswt_pkg.sv =====
// Shared types and constants of the priority schedule wait-time block.
package pswt_pkg;

  localparam int MAX_PROCS = 16;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int IDX_W     = 6;
  localparam int TIME_W    = 22;
  localparam int TOTAL_W   = 28;

  // One held job: arrival index, priority and burst.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } job_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // insert the new job this cycle
    logic shl;   // shift the chain one cell toward cell 0
    job_t job;   // the job being inserted
  } cell_ctl_t;

endpackage

// ===== src/priority_schedule_wait_times.sv =====
// Top level of the non-preemptive priority scheduler with wait-time results.
//
// Jobs arrive on the input channel (in_valid/in_ready) as requests carrying a
// burst time and a priority. Each accepted request is inserted into
// a chain of MAX_PROCS cells kept sorted by ascending priority value; a job with
// equal priority lands behind those already held, so ties keep arrival order.
// A request with last_job set closes the set. A job that arrives while the chain
// is full is dropped and every result of that set flags jobs_dropped.
// Loading takes one request per cycle. After the closing request the input side
// stalls while the chain shifts toward cell 0, one job per cycle while the
// receiver is ready, and each job leaves through the output register
// (out_valid/out_ready) with its waiting time, turnaround time and the running
// total of waiting times. The first result is loaded into the output register
// from the EMIT state that follows the closing request. A stalled receiver
// holds the output register and freezes the chain. The input channel reopens in
// the cycle after the last result is loaded into the output register. Reset
// empties the set and clears out_valid.
module priority_schedule_wait_times (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pswt_pkg::BURST_W-1:0]   burst_time,
  input  logic [pswt_pkg::PRIO_W-1:0]    priority_req,
  input  logic                           last_job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pswt_pkg::IDX_W-1:0]     job_number,
  output logic [pswt_pkg::TIME_W-1:0]    wait_time,
  output logic [pswt_pkg::TIME_W-1:0]    finish_time,
  output logic [pswt_pkg::TOTAL_W-1:0]   total_wait,
  output logic                           end_of_run,
  output logic                           jobs_dropped
);
  import pswt_pkg::*;

  typedef enum logic {LOAD, EMIT} state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic                 overflow;
  logic [TIME_W-1:0]    elapsed;
  logic [TOTAL_W-1:0]   total_acc;

  cell_ctl_t            ctl;
  job_t                 entries [MAX_PROCS];
  logic [MAX_PROCS-1:0] held;
  logic [MAX_PROCS-1:0] disp;

  logic in_acc;
  logic full;
  logic step;
  logic [TIME_W-1:0] fin_next;

  assign in_ready = (state == LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count == CNT_W'(MAX_PROCS));

  // In EMIT, a result is produced whenever the output register is free or being drained.
  assign step     = (state == EMIT) && (!out_valid || out_ready);
  assign fin_next = elapsed + TIME_W'(entries[0].burst);

  assign ctl.ins       = in_acc && !full;
  assign ctl.shl       = step;
  assign ctl.job.idx   = IDX_W'(count);
  assign ctl.job.prio  = priority_req;
  assign ctl.job.burst = burst_time;

  // The held jobs always form a prefix of the chain, so occupancy follows the count.
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign held[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      pswt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .held        (held[i]),
        .left_held   (1'b1),
        .left_disp   (1'b0),
        .left_entry  (ctl.job),
        .right_entry (entries[(i + 1) % MAX_PROCS]),
        .disp        (disp[i]),
        .entry       (entries[i])
      );
    end else if (i == MAX_PROCS - 1) begin : g_tail
      pswt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .held        (held[i]),
        .left_held   (held[i-1]),
        .left_disp   (disp[i-1]),
        .left_entry  (entries[i-1]),
        .right_entry (entries[i]),
        .disp        (disp[i]),
        .entry       (entries[i])
      );
    end else begin : g_mid
      pswt_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .held        (held[i]),
        .left_held   (held[i-1]),
        .left_disp   (disp[i-1]),
        .left_entry  (entries[i-1]),
        .right_entry (entries[i+1]),
        .disp        (disp[i]),
        .entry       (entries[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A drained output register empties unless a new result replaces it.
      if (out_valid && out_ready && !step) begin
        out_valid <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (in_acc) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (last_job) begin
              state     <= EMIT;
              elapsed   <= '0;
              total_acc <= '0;
            end
          end
        end
        EMIT: begin
          if (step) begin
            out_valid    <= 1'b1;
            job_number   <= entries[0].idx;
            wait_time    <= elapsed;
            finish_time  <= fin_next;
            total_wait   <= total_acc + TOTAL_W'(elapsed);
            end_of_run   <= (count == CNT_W'(1));
            jobs_dropped <= overflow;
            elapsed      <= fin_next;
            total_acc    <= total_acc + TOTAL_W'(elapsed);
            count        <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state    <= LOAD;
              overflow <= 1'b0;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // The chain never holds more jobs than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PROCS))
    else $error("job count exceeds chain capacity");

  // Emitting the final job empties the set and reopens the input.
  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    step && (count == CNT_W'(1)) |=> (state == LOAD) && (count == '0) && !overflow
                                     && out_valid && end_of_run)
    else $error("set not closed after final result");

  // Turnaround never falls below the waiting time.
  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finish_time >= wait_time)
    else $error("finish time below wait time");

endmodule

// ===== src/pswt_cell.sv =====
// One cell of the sorted job chain.
module pswt_cell (
  input  logic               clk,
  input  pswt_pkg::cell_ctl_t ctl,
  input  logic               held,
  input  logic               left_held,
  input  logic               left_disp,
  input  pswt_pkg::job_t     left_entry,
  input  pswt_pkg::job_t     right_entry,
  output logic               disp,
  output pswt_pkg::job_t     entry
);
  import pswt_pkg::*;

  // The held job gives way when the new job has a strictly smaller priority value.
  assign disp = held && (entry.prio > ctl.job.prio);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!held || disp) begin
        if (left_disp) begin
          entry <= left_entry;
        end else if (left_held) begin
          entry <= ctl.job;
        end
      end
    end else if (ctl.shl) begin
      entry <= right_entry;
    end
  end

endmodule
